### hdl/wavm_pkg.sv
`timescale 1ns / 1ps

package wavm_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int SLOT_LIMIT    = 64;
    localparam int DATA_W        = 32;
    localparam int SIZE_W        = 7;
    localparam int SLOT_W        = 6;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR   = 3'd0,
        CMD_SET     = 3'd1,
        CMD_GET     = 3'd2,
        CMD_COMPACT = 3'd3,
        CMD_DUMP    = 3'd4
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_OOB   = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REG_WINDOW_BASE = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } reg_index_t;

endpackage

### hdl/wavm_ram.sv
`timescale 1ns / 1ps

module wavm_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/windowed_array_with_valid_marks.sv
`timescale 1ns / 1ps
// Set writes the entry in ST_SET and raises the result strobe; get reads through ST_GET_ADDR and ST_GET_DATA.
// Dump reads the window slots in order through the registered store port and gives one result per cycle.
// Compact scans the window and then empties the freed entries, one a cycle.
// Clear, and the sweep that follows reset, empty the store one entry per cycle.
// After reset the block is busy until that sweep is done; results cannot be stalled by the receiver.
module windowed_array_with_valid_marks #(
    parameter int DEPTH = wavm_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [wavm_pkg::CMD_W-1:0]    command,
    input  logic [wavm_pkg::DATA_W-1:0]   element_index,
    input  logic [wavm_pkg::DATA_W-1:0]   write_value,
    output logic                          result_valid,
    output logic [wavm_pkg::STATUS_W-1:0] status,
    output logic [wavm_pkg::DATA_W-1:0]   read_value,
    output logic [wavm_pkg::SLOT_W-1:0]   slot,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [wavm_pkg::DATA_W-1:0]   cfg_data
);

    import wavm_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIMIT = (DEPTH < SLOT_LIMIT) ? DEPTH : SLOT_LIMIT;
    localparam int RAM_W = DATA_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_GET_ADDR,
        ST_GET_DATA,
        ST_DUMP,
        ST_COMPACT_SCAN,
        ST_COMPACT_FILL
    } state_t;

    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   base_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [DATA_W-1:0]   index_reg, index_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic [SIZE_W-1:0]   cnt_reg, cnt_next;
    logic [SIZE_W-1:0]   dst_reg, dst_next;
    logic                pend_reg, pend_next;
    logic [SIZE_W-1:0]   pend_slot_reg, pend_slot_next;
    logic                strobe_reg, strobe_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   rv_reg, rv_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                last_reg, last_next;

    logic [SIZE_W-1:0]   used_n;
    logic [DATA_W:0]     off_wide;
    logic                in_window;
    logic [AW-1:0]       off_addr;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [RAM_W-1:0]    ram_rdata;

    function automatic logic [AW-1:0] to_addr(input logic [SIZE_W-1:0] v);
        logic [AW+SIZE_W-1:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    wavm_ram #(
        .WIDTH(RAM_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            size_reg <= SIZE_W'(SLOT_LIMIT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_BASE: base_reg <= cfg_data;
                REG_WINDOW_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign used_n    = (size_reg > SIZE_W'(LIMIT)) ? SIZE_W'(LIMIT) : size_reg;
    assign off_wide  = {index_reg[DATA_W-1], index_reg} - {base_reg[DATA_W-1], base_reg};
    assign in_window = !off_wide[DATA_W]
                       && (off_wide[DATA_W-1:0] < {{(DATA_W-SIZE_W){1'b0}}, used_n});
    assign off_addr  = to_addr(off_wide[SIZE_W-1:0]);

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        pend_slot_next = pend_slot_reg;
        strobe_next    = 1'b0;
        status_next    = STATUS_OK;
        rv_next        = '0;
        slot_next      = '0;
        last_next      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    index_next = element_index;
                    value_next = write_value;
                    case (command)
                        CMD_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_SET:     state_next = ST_SET;
                        CMD_GET:     state_next = ST_GET_ADDR;
                        CMD_COMPACT:
                        begin
                            cnt_next   = used_n;
                            dst_next   = used_n;
                            pend_next  = 1'b0;
                            state_next = ST_COMPACT_SCAN;
                        end
                        CMD_DUMP:
                        begin
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_DUMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SET:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (in_window)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = off_addr;
                    ram_wdata = {1'b1, value_reg};
                end
                else
                begin
                    status_next = STATUS_OOB;
                end
                state_next = ST_IDLE;
            end
            ST_GET_ADDR:
            begin
                ram_raddr = off_addr;
                if (in_window)
                begin
                    state_next = ST_GET_DATA;
                end
                else
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    status_next = STATUS_OOB;
                    state_next  = ST_IDLE;
                end
            end
            ST_GET_DATA:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (ram_rdata[DATA_W])
                begin
                    rv_next = ram_rdata[DATA_W-1:0];
                end
                else
                begin
                    status_next = STATUS_EMPTY;
                end
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                if (pend_reg)
                begin
                    strobe_next = 1'b1;
                    slot_next   = pend_slot_reg[SLOT_W-1:0];
                    last_next   = ((pend_slot_reg + 1'b1) == used_n);
                    if (ram_rdata[DATA_W])
                    begin
                        rv_next = ram_rdata[DATA_W-1:0];
                    end
                    else
                    begin
                        status_next = STATUS_EMPTY;
                    end
                end
                if (cnt_reg < used_n)
                begin
                    ram_raddr      = to_addr(cnt_reg);
                    cnt_next       = cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = cnt_reg;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_COMPACT_SCAN:
            begin
                if (pend_reg && ram_rdata[DATA_W])
                begin
                    dst_next  = dst_reg - 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(dst_reg - 1'b1);
                    ram_wdata = {1'b1, ram_rdata[DATA_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    ram_raddr = to_addr(cnt_reg - 1'b1);
                    cnt_next  = cnt_reg - 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_COMPACT_FILL;
                end
            end
            ST_COMPACT_FILL:
            begin
                if (cnt_reg < dst_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = to_addr(cnt_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            index_reg     <= '0;
            value_reg     <= '0;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            dst_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_slot_reg <= '0;
            strobe_reg    <= 1'b0;
            status_reg    <= STATUS_OK;
            rv_reg        <= '0;
            slot_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            value_reg     <= value_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            dst_reg       <= dst_next;
            pend_reg      <= pend_next;
            pend_slot_reg <= pend_slot_next;
            strobe_reg    <= strobe_next;
            status_reg    <= status_next;
            rv_reg        <= rv_next;
            slot_reg      <= slot_next;
            last_reg      <= last_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = strobe_reg;
    assign status       = status_reg;
    assign read_value   = rv_reg;
    assign slot         = slot_reg;
    assign last         = last_reg;

endmodule
